FILE: rtl/core/per_cpu_page_free_list_allocator_assert.svh
// Assertion macros shared by the allocator RTL.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCPFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PCPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pcpfa_pkg.sv
`default_nettype none

package pcpfa_pkg;

  localparam int NUM_CPUS   = 8;
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int CPU_W      = 3;
  localparam int HEAD_W     = 16;
  localparam int LINK_AW    = $clog2(NUM_PAGES);
  localparam int CFG_IDX_W  = 4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIMIT = CFG_IDX_W'(1);

  localparam logic [31:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [31:0] REGION_LIMIT_RST = 32'h8800_0000;

  localparam logic [HEAD_W-1:0] EMPTY_MARK = HEAD_W'(NUM_PAGES);

  typedef struct packed {
    logic              operation;
    logic [CPU_W-1:0]  requester_cpu;
    logic [31:0]       page_address;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [1:0]  status;
  } rsp_t;

  // First page of the region: start rounded up to a page boundary, kept at 33 bits
  // so that a round-up past the top of the address space stays visible.
  function automatic logic [32:0] round_up_page(input logic [31:0] start);
    logic [32:0] sum;
    sum = {1'b0, start} + 33'(PAGE_BYTES - 1);
    return {sum[32:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/per_cpu_page_free_list_allocator.sv
// Per-CPU page free-list allocator with stealing.
// Requests arrive on the in_ channel (valid/ready) as a pcpfa_pkg::req_t: an
// allocate or free, the requesting CPU and, for a free, a page address. Each
// request yields exactly one response on the out_ channel as a rsp_t holding
// the granted address and a status (ok, out of memory, bad address).
// Registers region_start and region_limit are written through the cfg_ port,
// which is ready while the block is idle; write them only with no request in flight.
// Each CPU owns a LIFO free list: its head sits in a flip-flop, the links live
// in a single-port synchronous memory with one entry per page.
// A free or an out-of-memory allocate loads the response register at the end of
// its execute step; an allocate that pops takes an extra step, the read of the
// link memory before the head can be updated. in_ready returns as the response
// is loaded, so the block takes no new request before the last one finishes. A
// new request is accepted while the previous response waits. If the receiver
// stalls, the response register holds and a finished request waits in its last
// step.
// Synchronous reset empties every list and restores the region registers;
// the link memory is not cleared since only pushed pages are ever linked.
`default_nettype none

module per_cpu_page_free_list_allocator (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire pcpfa_pkg::req_t         in_req,
  output logic                         out_valid,
  input  wire                          out_ready,
  output pcpfa_pkg::rsp_t              out_rsp,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [pcpfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [31:0]                   cfg_data
);
  import pcpfa_pkg::*;

  `include "per_cpu_page_free_list_allocator_assert.svh"

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  req_t              req_r;
  logic [32:0]       first_page_r;
  logic [31:0]       region_limit_r;
  logic [HEAD_W-1:0] head_r [NUM_CPUS];
  logic [CPU_W-1:0]  pop_cpu_r;
  logic [HEAD_W-1:0] pop_page_r;
  logic              out_valid_r;
  rsp_t              out_rsp_r;

  // Link memory: one entry per page, one access per cycle.
  logic [HEAD_W-1:0] next_link_mem [NUM_PAGES];
  logic [HEAD_W-1:0] link_rdata_r;
  logic              link_we, link_re;
  logic [LINK_AW-1:0] link_addr;
  logic [HEAD_W-1:0] link_wdata;

  logic              out_free;
  logic              rsp_load;
  logic              cfg_we;

  // Free address check.
  logic              cpu_ok;
  logic [32:0]       addr_diff;
  logic              free_ok;
  logic [HEAD_W-1:0] free_idx;

  // Victim selection for an allocate.
  logic [NUM_CPUS-1:0] nonempty;
  logic                any_nonempty;
  logic [CPU_W-1:0]    victim;

  assign cfg_ready = rst_n && (state_r == S_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign out_free  = !out_valid_r || out_ready;

  // The response register is loaded when a free or an out-of-memory allocate
  // finishes its execute step, or when a pop completes.
  assign rsp_load  = out_free
                  && ((state_r == S_EXEC && (req_r.operation == OP_FREE || !any_nonempty))
                   || state_r == S_POP);

  assign cpu_ok    = 32'(req_r.requester_cpu) < 32'(NUM_CPUS);
  assign addr_diff = {1'b0, req_r.page_address} - first_page_r;
  assign free_idx  = HEAD_W'(addr_diff[31:PAGE_SHIFT]);
  // Valid CPU, aligned, not below the first page, below the limit, and inside the page count.
  assign free_ok   = cpu_ok
                  && (req_r.page_address[PAGE_SHIFT-1:0] == '0)
                  && ({1'b0, req_r.page_address} >= first_page_r)
                  && (req_r.page_address < region_limit_r)
                  && (32'(addr_diff[31:PAGE_SHIFT]) < 32'(NUM_PAGES));

  always_comb begin
    for (int i = 0; i < NUM_CPUS; i++) begin
      nonempty[i] = head_r[i] < EMPTY_MARK;
    end
  end

  assign any_nonempty = |nonempty;

  // The requester's own list first; otherwise the lowest-numbered non-empty
  // list, which cannot be the requester's since that one is empty.
  always_comb begin
    victim = '0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        victim = CPU_W'(i);
      end
    end
    if (cpu_ok && nonempty[req_r.requester_cpu]) begin
      victim = req_r.requester_cpu;
    end
  end

  // Link memory controls, in S_EXEC: a valid free writes, an allocate with a non-empty list reads.
  always_comb begin
    link_we    = 1'b0;
    link_re    = 1'b0;
    link_addr  = head_r[victim][LINK_AW-1:0];
    link_wdata = head_r[req_r.requester_cpu];
    if (state_r == S_EXEC && out_free) begin
      if (req_r.operation == OP_FREE) begin
        link_we   = free_ok;
        link_addr = free_idx[LINK_AW-1:0];
      end else begin
        link_re = any_nonempty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      next_link_mem[link_addr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata_r <= next_link_mem[link_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          if (req_r.operation == OP_ALLOC && any_nonempty) state_nxt = S_POP;
          else state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      first_page_r   <= round_up_page(REGION_START_RST);
      region_limit_r <= REGION_LIMIT_RST;
      for (int i = 0; i < NUM_CPUS; i++) begin
        head_r[i] <= EMPTY_MARK;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        if (cfg_index == CFG_REGION_START) first_page_r <= round_up_page(cfg_data);
        else if (cfg_index == CFG_REGION_LIMIT) region_limit_r <= cfg_data;
      end

      if (rsp_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == S_EXEC && out_free && req_r.operation == OP_FREE && free_ok) begin
        // Push: the old head was written into the page's link this cycle.
        head_r[req_r.requester_cpu] <= free_idx;
      end

      if (state_r == S_POP && out_free) begin
        head_r[pop_cpu_r] <= link_rdata_r;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
    if (state_r == S_EXEC && out_free) begin
      pop_cpu_r  <= victim;
      pop_page_r <= head_r[victim];
      if (req_r.operation == OP_FREE) begin
        out_rsp_r.granted_address <= '0;
        out_rsp_r.status          <= free_ok ? ST_OK : ST_BAD;
      end else if (!any_nonempty) begin
        out_rsp_r.granted_address <= '0;
        out_rsp_r.status          <= ST_OOM;
      end
    end
    if (state_r == S_POP && out_free) begin
      out_rsp_r.granted_address <= first_page_r[31:0]
                                 + (32'(pop_page_r) << PAGE_SHIFT);
      out_rsp_r.status          <= ST_OK;
    end
  end

  // A pop only starts from a list that was non-empty, and nothing touches
  // that head before the pop completes.
  `PCPFA_ASSERT_NOW(a_pop_head_valid, state_r == S_POP, head_r[pop_cpu_r] < EMPTY_MARK, "pop from empty list")
  // Every non-ok response carries a zero address.
  `PCPFA_ASSERT_NOW(a_err_addr_zero, out_valid_r && out_rsp_r.status != ST_OK, out_rsp_r.granted_address == '0, "error response with address")
  // A response is only loaded at the end of a request.
  `PCPFA_ASSERT_NEXT(a_rsp_source, !out_valid_r && state_r == S_IDLE, !out_valid_r, "response without request")
  // An accepted request always moves into execution.
  `PCPFA_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_r == S_EXEC, "accepted request not executed")

endmodule

`default_nettype wire
